[rtl/chd_pkg.sv]
`default_nettype none
package chd_pkg;

    localparam int SIZE_BITS_DEF = 31;

    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] out_byte;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

[rtl/http_chunked_body_decoder.sv]
`default_nettype none
// Chunked body decoder: one body byte (or a clear command) per beat, one result beat per
// input beat, at one beat per clock while o_stall is low. Each byte updates the decoder
// state through a hex decode plus a shift-or of the size, or a decrement of the chunk
// byte count, and the result is registered; a two-entry output buffer accepts one more
// input beat after the output side stalls, then o_stall rises. When the output is free,
// an accepted beat is on o_valid in the next cycle. status is the state after the byte:
// complete and malformed stay until a clear. Chunk sizes up to 2^SIZE_BITS - 1 bytes.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_func,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_data_valid,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_status
);

    logic             accept;
    chd_pkg::t_result core_res;
    chd_pkg::t_result out_res;

    assign accept = i_valid && !o_stall;

    chd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_func    (i_func),
        .i_in_byte (i_in_byte),
        .o_result  (core_res)
    );

    chd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_result (core_res),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (out_res),
        .o_full   (o_stall)
    );

    assign o_data_valid = out_res.data_valid;
    assign o_out_byte   = out_res.out_byte;
    assign o_status     = out_res.status;

endmodule
`default_nettype wire

[rtl/chd_core.sv]
`default_nettype none
module chd_core #(
    parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_func,
    input  wire logic [7:0]       i_in_byte,
    output chd_pkg::t_result      o_result
);

    typedef enum logic [2:0] {
        M_SKIP,
        M_SIZE,
        M_DATA,
        M_DONE,
        M_ERR
    } t_mode;

    t_mode                r_mode, n_mode;
    logic [SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [SIZE_BITS-1:0] r_size_accum, n_size_accum;
    logic                 r_digit_seen, n_digit_seen;
    logic                 r_ext_skip, n_ext_skip;
    logic                 r_nonempty, n_nonempty;

    chd_pkg::t_hex        hv;
    logic                 size_line;
    logic [SIZE_BITS-1:0] dec_left;

    always_comb begin
        n_mode       = r_mode;
        n_bytes_left = r_bytes_left;
        n_size_accum = r_size_accum;
        n_digit_seen = r_digit_seen;
        n_ext_skip   = r_ext_skip;
        n_nonempty   = r_nonempty;
        o_result     = '0;
        size_line    = 1'b0;
        hv           = chd_pkg::hex_decode(i_in_byte);
        dec_left     = (r_bytes_left == '0) ? '0 : r_bytes_left - SIZE_BITS'(1);

        if (i_func == chd_pkg::FUNC_CLEAR) begin
            n_mode       = M_SKIP;
            n_bytes_left = '0;
            n_size_accum = '0;
            n_digit_seen = 1'b0;
            n_ext_skip   = 1'b0;
            n_nonempty   = 1'b0;
        end else begin
            case (r_mode)
                M_SKIP: begin
                    if (i_in_byte != chd_pkg::CHAR_CR && i_in_byte != chd_pkg::CHAR_LF) begin
                        n_mode    = M_SIZE;
                        size_line = 1'b1;
                    end
                end
                M_SIZE: size_line = 1'b1;
                M_DATA: begin
                    o_result.data_valid = 1'b1;
                    o_result.out_byte   = i_in_byte;
                    n_nonempty          = 1'b1;
                    n_bytes_left        = dec_left;
                    if (dec_left == '0) begin
                        n_mode = M_SKIP;
                    end
                end
                M_DONE: ;
                default: n_mode = M_ERR;
            endcase
        end

        if (size_line) begin
            if (i_in_byte == chd_pkg::CHAR_LF) begin
                // line end: the gathered size takes effect
                if (!r_digit_seen) begin
                    n_mode = M_ERR;
                end else if (r_size_accum == '0) begin
                    n_mode = r_nonempty ? M_DONE : M_ERR;
                end else begin
                    n_bytes_left = r_size_accum;
                    n_mode       = M_DATA;
                end
                n_size_accum = '0;
                n_digit_seen = 1'b0;
                n_ext_skip   = 1'b0;
            end else if (!r_ext_skip) begin
                if (!hv.ok) begin
                    n_ext_skip = 1'b1;
                end else if (r_size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                    // next digit would overflow the size
                    n_mode = M_ERR;
                end else begin
                    n_size_accum = {r_size_accum[SIZE_BITS-5:0], hv.val};
                    n_digit_seen = 1'b1;
                end
            end
        end

        if (n_mode == M_DONE) begin
            o_result.status = chd_pkg::ST_DONE;
        end else if (n_mode == M_ERR) begin
            o_result.status = chd_pkg::ST_ERR;
        end else begin
            o_result.status = chd_pkg::ST_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_SKIP;
            r_bytes_left <= '0;
            r_size_accum <= '0;
            r_digit_seen <= 1'b0;
            r_ext_skip   <= 1'b0;
            r_nonempty   <= 1'b0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_bytes_left <= n_bytes_left;
            r_size_accum <= n_size_accum;
            r_digit_seen <= n_digit_seen;
            r_ext_skip   <= n_ext_skip;
            r_nonempty   <= n_nonempty;
        end
    end

`ifndef SYNTHESIS
    a_data_only_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.data_valid) |-> (r_mode == M_DATA))
        else $error("payload byte produced outside chunk data");

    a_data_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_DATA) |-> (r_bytes_left != '0))
        else $error("in chunk data with no bytes left");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_func == chd_pkg::FUNC_CLEAR) |=>
            (r_mode == M_SKIP && r_size_accum == '0 && !r_nonempty))
        else $error("clear did not reset decoder");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_mode == M_DONE && i_func == chd_pkg::FUNC_BYTE) |=>
            (r_mode == M_DONE))
        else $error("complete status lost without clear");
`endif

endmodule
`default_nettype wire

[rtl/chd_out.sv]
`default_nettype none
module chd_out (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  chd_pkg::t_result      i_result,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output chd_pkg::t_result      o_result,
    output logic                  o_full
);

    logic             r_out_v;
    logic             r_skid_v;
    chd_pkg::t_result r_out;
    chd_pkg::t_result r_skid;
    logic             take;

    assign take     = r_out_v && !i_stall;
    assign o_valid  = r_out_v;
    assign o_result = r_out;
    assign o_full   = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take || !r_out_v) begin
            // output register frees up: drain skid first, then the new beat
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= i_push;
                if (i_push) begin
                    r_skid <= i_result;
                end
            end else begin
                r_out_v <= i_push;
                if (i_push) begin
                    r_out <= i_result;
                end
            end
        end else if (i_push) begin
            r_skid   <= i_result;
            r_skid_v <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a beat while output is empty");

    a_held_push_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_out_v && i_stall) |=> (r_skid_v && r_out_v))
        else $error("beat pushed under stall was not parked");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !take) |-> !i_push)
        else $error("beat pushed into full buffer");
`endif

endmodule
`default_nettype wire
